// File: src/tilt_state_detector_core_defines.svh
// Assertion helpers used by the tilt detector core.
`ifndef TILT_STATE_DETECTOR_CORE_DEFINES_SVH
`define TILT_STATE_DETECTOR_CORE_DEFINES_SVH

// Check a property on every rising edge of clk_i, off while rst_ni is low.
`define TDET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define TDET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tdet_pkg.sv
package tdet_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ELAPSED_W  = 16;
  localparam int THR_W      = 15;
  localparam int HOLD_W     = 16;
  localparam int TILT_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Tilt state codes
  localparam logic [TILT_W-1:0] TILT_FLAT = 2'd0;
  localparam logic [TILT_W-1:0] TILT_UP   = 2'd1;
  localparam logic [TILT_W-1:0] TILT_DN   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_MS     = 8'd1;

  // Register reset values
  localparam int THR_RESET  = 1000;
  localparam int HOLD_RESET = 500;

  // One accepted beat as seen by the decision logic
  typedef struct packed {
    logic                 step;     // beat carries a sample (elapsed nonzero)
    logic [ELAPSED_W-1:0] elapsed;
  } tdet_step_t;

endpackage

// File: src/tdet_cell.sv
module tdet_cell
  import tdet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic [SAMPLE_W-1:0] d_i,
  output logic [SAMPLE_W-1:0] q_o
);

  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] sample_d;

  // Take the neighbor's sample on a shift, else hold
  assign sample_d = shift_i ? d_i : sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign q_o = sample_q;

endmodule

// File: src/tdet_ctrl.sv
module tdet_ctrl
  import tdet_pkg::*;
#(
  parameter int SumW = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tdet_step_t             step_i,
  input  logic signed [SumW-1:0] sum_i,
  input  logic        [SumW-1:0] lim_i,
  input  logic      [HOLD_W-1:0] holdoff_i,
  output logic      [TILT_W-1:0] tilt_o
);

  logic [TILT_W-1:0]      tilt_q, tilt_d;
  logic [HOLD_W-1:0]      hold_q, hold_d;
  logic [HOLD_W-1:0]      hold_cnt;
  logic signed [SumW-1:0] lim_pos;
  logic signed [SumW-1:0] lim_neg;
  logic                   below_hit;
  logic                   above_hit;
  logic                   move;

  // Count the holdoff down, saturating at zero
  assign hold_cnt = (step_i.elapsed >= hold_q) ? '0 : hold_q - step_i.elapsed;

  // Compare the window sum against +/- threshold scaled by the window length
  assign lim_pos   = $signed(lim_i);
  assign lim_neg   = -lim_pos;
  assign below_hit = sum_i < lim_neg;
  assign above_hit = sum_i > lim_pos;

  // Pick the next tilt state
  always_comb begin
    tilt_d = tilt_q;
    move   = 1'b0;
    if (step_i.step && (hold_cnt == '0)) begin
      unique case (tilt_q)
        TILT_FLAT: begin
          if (below_hit) begin
            tilt_d = TILT_UP;
            move   = 1'b1;
          end else if (above_hit) begin
            tilt_d = TILT_DN;
            move   = 1'b1;
          end
        end
        TILT_UP: begin
          if (above_hit) begin
            tilt_d = TILT_FLAT;
            move   = 1'b1;
          end
        end
        TILT_DN: begin
          if (below_hit) begin
            tilt_d = TILT_FLAT;
            move   = 1'b1;
          end
        end
        default: begin
          tilt_d = tilt_q;
        end
      endcase
    end
  end

  // Reload the holdoff on a move, else advance the countdown
  always_comb begin
    hold_d = hold_q;
    if (move) begin
      hold_d = holdoff_i;
    end else if (step_i.step) begin
      hold_d = hold_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q <= TILT_FLAT;
      hold_q <= '0;
    end else begin
      tilt_q <= tilt_d;
      hold_q <= hold_d;
    end
  end

  assign tilt_o = tilt_q;

endmodule

// File: src/tilt_state_detector_core.sv
// Tilt state detector: boxcar-averaged gyro rate with threshold and holdoff.
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while in_stall_o is low; the running window sum
// and state decision are both combinational between input and output register.
// Reset (async, active low) clears the sample cells, window sum, tilt state and
// holdoff, and loads the threshold and holdoff registers with their defaults.
`include "tilt_state_detector_core_defines.svh"

module tilt_state_detector_core
  import tdet_pkg::*;
#(
  parameter int AVG_LENGTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   rate_sample_i,
  input  logic [ELAPSED_W-1:0]  elapsed_ms_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TILT_W-1:0]     tilt_state_o,
  // Configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int HistDepth = AVG_LENGTH - 1;
  localparam int SumW      = SAMPLE_W + 1 + $clog2(AVG_LENGTH);
  localparam int LimW      = THR_W + $clog2(AVG_LENGTH);

  logic                   in_accept;
  logic                   shift;
  tdet_step_t             step;
  logic [SAMPLE_W-1:0]    tap_w [HistDepth+1];
  logic signed [SumW-1:0] sample_ext;
  logic signed [SumW-1:0] oldest_ext;
  logic signed [SumW-1:0] hsum_q, hsum_d;
  logic signed [SumW-1:0] win_sum;
  logic [LimW-1:0]        lim_q, lim_d;
  logic [HOLD_W-1:0]      holdoff_q, holdoff_d;
  logic                   out_valid_q, out_valid_d;

  // Handshake: a new beat enters whenever the result slot is free or draining
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign shift       = in_accept & (elapsed_ms_i != '0);
  assign cfg_ready_o = 1'b1;

  // Configuration registers; the threshold is kept pre-scaled by the window length
  always_comb begin
    lim_d     = lim_q;
    holdoff_d = holdoff_q;
    if (cfg_valid_i) begin
      priority if (cfg_index_i == CFG_RATE_THRESHOLD) begin
        lim_d = LimW'(cfg_data_i[THR_W-1:0]) * LimW'(AVG_LENGTH);
      end else if (cfg_index_i == CFG_HOLDOFF_MS) begin
        holdoff_d = cfg_data_i[HOLD_W-1:0];
      end else begin
        lim_d = lim_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q     <= LimW'(THR_RESET * AVG_LENGTH);
      holdoff_q <= HOLD_W'(HOLD_RESET);
    end else begin
      lim_q     <= lim_d;
      holdoff_q <= holdoff_d;
    end
  end

  // Sample history as a row of shift cells
  assign tap_w[0] = rate_sample_i;

  for (genvar k = 0; k < HistDepth; k++) begin : g_cell
    tdet_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (tap_w[k]),
      .q_o     (tap_w[k+1])
    );
  end

  // Running sum of the history: add the new sample, drop the one leaving the row
  assign sample_ext = SumW'($signed(rate_sample_i));
  assign oldest_ext = SumW'($signed(tap_w[HistDepth]));
  assign win_sum    = hsum_q + sample_ext;
  assign hsum_d     = shift ? (win_sum - oldest_ext) : hsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsum_q <= '0;
    end else begin
      hsum_q <= hsum_d;
    end
  end

  // Tilt decision and holdoff timer
  assign step.step    = shift;
  assign step.elapsed = elapsed_ms_i;

  tdet_ctrl #(
    .SumW (SumW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .sum_i     (win_sum),
    .lim_i     (SumW'(lim_q)),
    .holdoff_i (holdoff_q),
    .tilt_o    (tilt_state_o)
  );

  // Result valid: set on an accepted beat, drop once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TDET_ASSERT(a_no_overrun, (out_valid_o && out_stall_i) |-> in_stall_o, "input taken over a held result")
  `TDET_ASSERT_NEXT(a_result_follows, in_accept, out_valid_o, "accepted beat gave no result")
  `TDET_ASSERT_NEXT(a_query_keeps, in_accept && (elapsed_ms_i == '0), $stable(tilt_state_o), "query beat changed tilt")
  `TDET_ASSERT(a_change_needs_step, !$stable(tilt_state_o) |-> $past(shift), "tilt changed without a sample")

endmodule
